@@ hw/rtl/bsbe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline basis evaluator package
// Shared payload types, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package bsbe_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int unsigned VAL_W = 17;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] REG_DEGREE     = 2'd0;
    localparam logic [1:0] REG_NUM_POINTS = 2'd1;

    typedef struct packed {
        logic        operation;
        logic [6:0]  knot_index;
        logic [16:0] knot_value;
        logic [16:0] param_value;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  span;
        logic [2:0]  basis_index;
        logic [16:0] basis_value;
        logic        last;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_KN,
        ST_RD_KD,
        ST_CMP,
        ST_BS_RD,
        ST_BS_CMP,
        ST_J_START,
        ST_RD_L,
        ST_RD_R,
        ST_CALC_LR,
        ST_TERM,
        ST_MUL,
        ST_DIV_A,
        ST_DIV_B,
        ST_ACC,
        ST_J_END,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/bspline_basis_evaluator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline basis evaluator
// Cox-de Boor basis values at t over a knot vector held in a memory with one
// write and one read port. Span search by bisection, then one serial divider shared by both divisions of each term.
// ----------------------------------------------------------------------------
// A knot write is stored at its accepting edge. An evaluation runs the span
// search, then the recurrence on a 36-bit serial restoring divider (one
// quotient bit a cycle, two divisions a term), then emits degree+1 results.
// Throughput: one transaction at a time; the next is taken once the last
// result has left the output register. Reset: synchronous active low; degree
// returns to 3, num_points to 4. The knot memory is not cleared.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator #(
    parameter int unsigned KNOT_DEPTH = 128,
    parameter int unsigned MAX_DEGREE = 7
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  bsbe_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output bsbe_pkg::t_out_item    o_out_data,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [2:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned AW   = $clog2(KNOT_DEPTH);
    localparam int unsigned DW   = $clog2(MAX_DEGREE + 2);
    localparam int unsigned NB   = MAX_DEGREE + 2;
    // index arithmetic width: span + degree fits
    localparam int unsigned IW   = (AW > 9) ? AW : 9;
    localparam int unsigned DIVW = 36;

    // ---------------------------------------------------------------- config
    logic [2:0] r_degree;
    logic [6:0] r_num_points;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree     <= 3'd3;
            r_num_points <= 7'd4;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                bsbe_pkg::REG_DEGREE[0]:     r_degree     <= pwdata[2:0];
                bsbe_pkg::REG_NUM_POINTS[0]: r_num_points <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bsbe_pkg::REG_DEGREE[0]: prdata = {29'd0, r_degree};
            default:                 prdata = {25'd0, r_num_points};
        endcase
    end

    // ---------------------------------------------------------------- memory
    logic [16:0]  r_mem [KNOT_DEPTH];
    logic [16:0]  r_rd_data;
    logic         r_rd_ok;
    logic [IW-1:0] rd_addr;
    logic         mem_we;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[AW'(i_in_data.knot_index)] <= i_in_data.knot_value;
        r_rd_data <= r_mem[rd_addr[AW-1:0]];
        r_rd_ok   <= (32'(rd_addr) < KNOT_DEPTH);
    end

    logic [16:0] knot_q;
    assign knot_q = r_rd_ok ? r_rd_data : 17'd0;

    // ---------------------------------------------------------------- state
    bsbe_pkg::t_state r_state, n_state;

    logic [DW-1:0]  r_d;
    logic [IW-1:0]  r_n, r_lo, r_hi, r_span;
    logic [16:0]    r_t, r_kn, r_tc;
    logic [DW-1:0]  r_j, r_r, r_oj;
    logic signed [18:0] r_left  [NB];
    logic signed [18:0] r_right [NB];
    logic [16:0]    r_basis [NB];
    logic signed [DIVW-1:0] r_saved, r_qa;
    logic signed [19:0] r_den;
    logic [DIVW-1:0] r_quo, r_rem, r_dvd;
    logic [19:0]    r_dvs;
    logic [5:0]     r_cnt;
    logic           r_neg, r_bterm;
    logic           r_ov;
    bsbe_pkg::t_out_item r_out;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != bsbe_pkg::ST_IDLE) || r_ov;
    assign mem_we = in_acc && (i_in_data.operation == bsbe_pkg::OP_WRITE)
                    && (32'(i_in_data.knot_index) < KNOT_DEPTH);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // effective degree and points
    logic [DW-1:0] d_eff;
    logic [IW-1:0] n_eff;
    always_comb begin
        d_eff = (r_degree > 3'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(r_degree);
        n_eff = (IW'(r_num_points) < IW'(d_eff) + 1'b1) ? IW'(d_eff) + 1'b1
                                                         : IW'(r_num_points);
    end

    logic [IW-1:0] mid;
    assign mid = (r_lo + r_hi) >> 1;

    // saturate helper
    function automatic logic [16:0] sat_u(input logic signed [DIVW:0] v);
        if (v < 0) return 17'd0;
        if (v > signed'((DIVW+1)'(bsbe_pkg::ONE_Q16))) return bsbe_pkg::ONE_Q16;
        return v[16:0];
    endfunction

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsbe_pkg::ST_IDLE:
                if (in_acc && i_in_data.operation == bsbe_pkg::OP_EVAL)
                    n_state = bsbe_pkg::ST_RD_KN;
            bsbe_pkg::ST_RD_KN:  n_state = bsbe_pkg::ST_RD_KD;
            bsbe_pkg::ST_RD_KD:  n_state = bsbe_pkg::ST_CMP;
            bsbe_pkg::ST_CMP:
                if ({1'b0, r_t} >= {1'b0, r_kn} || r_t <= knot_q || r_n - r_lo <= 1)
                    n_state = bsbe_pkg::ST_J_START;
                else
                    n_state = bsbe_pkg::ST_BS_RD;
            bsbe_pkg::ST_BS_RD:  n_state = bsbe_pkg::ST_BS_CMP;
            bsbe_pkg::ST_BS_CMP: begin
                if (((r_t < knot_q) ? mid : r_hi) - ((r_t < knot_q) ? r_lo : mid) > 1)
                    n_state = bsbe_pkg::ST_BS_RD;
                else
                    n_state = bsbe_pkg::ST_J_START;
            end
            bsbe_pkg::ST_J_START:
                n_state = (r_j > r_d) ? bsbe_pkg::ST_EMIT : bsbe_pkg::ST_RD_L;
            bsbe_pkg::ST_RD_L:   n_state = bsbe_pkg::ST_RD_R;
            bsbe_pkg::ST_RD_R:   n_state = bsbe_pkg::ST_CALC_LR;
            bsbe_pkg::ST_CALC_LR: n_state = bsbe_pkg::ST_TERM;
            bsbe_pkg::ST_TERM:   n_state = bsbe_pkg::ST_MUL;
            bsbe_pkg::ST_MUL:    n_state = bsbe_pkg::ST_DIV_A;
            bsbe_pkg::ST_DIV_A:
                if (r_cnt == 6'd0) n_state = bsbe_pkg::ST_DIV_B;
            bsbe_pkg::ST_DIV_B:
                if (r_cnt == 6'd0) n_state = bsbe_pkg::ST_ACC;
            bsbe_pkg::ST_ACC:
                n_state = (r_r + 1'b1 == r_j) ? bsbe_pkg::ST_J_END : bsbe_pkg::ST_TERM;
            bsbe_pkg::ST_J_END:  n_state = bsbe_pkg::ST_J_START;
            bsbe_pkg::ST_EMIT:
                if ((!r_ov || !i_out_stall) && r_oj == r_d) n_state = bsbe_pkg::ST_IDLE;
            default: n_state = bsbe_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- read address
    always_comb begin
        case (r_state)
            bsbe_pkg::ST_IDLE:   rd_addr = n_eff;
            bsbe_pkg::ST_RD_KN:  rd_addr = r_n;
            bsbe_pkg::ST_RD_KD:  rd_addr = IW'(r_d);
            bsbe_pkg::ST_CMP,
            bsbe_pkg::ST_BS_RD:  rd_addr = mid;
            bsbe_pkg::ST_RD_L:   rd_addr = r_span + 1'b1 - IW'(r_j);
            bsbe_pkg::ST_RD_R:   rd_addr = r_span + IW'(r_j);
            default:             rd_addr = mid;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    logic signed [19:0] num_sel;
    logic [19:0]        num_abs;
    logic [DIVW:0]      div_try;
    logic               div_zero;
    assign num_sel = r_bterm ? 20'(r_left[r_j - r_r]) : 20'(r_right[r_r + 1'b1]);
    assign num_abs = (num_sel < 0) ? 20'(-num_sel) : 20'(num_sel);
    assign div_try = {r_rem[DIVW-2:0], r_dvd[DIVW-1]} - {17'd0, r_dvs};
    assign div_zero = (r_den == 20'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsbe_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            if (r_state == bsbe_pkg::ST_EMIT && (!r_ov || !i_out_stall)) r_ov <= 1'b1;
        end

        case (r_state)
            bsbe_pkg::ST_IDLE: begin
                r_d  <= d_eff;
                r_n  <= n_eff;
                r_lo <= IW'(d_eff);
                r_hi <= n_eff;
                r_t  <= i_in_data.param_value;
                r_j  <= DW'(1);
                r_oj <= '0;
                r_basis[0] <= bsbe_pkg::ONE_Q16;
            end
            bsbe_pkg::ST_RD_KD: r_kn <= knot_q;
            bsbe_pkg::ST_CMP: begin
                if (r_t >= r_kn) r_span <= r_n - 1'b1;
                else if (r_t <= knot_q) r_span <= IW'(r_d);
                else r_span <= r_lo;
                // clamp t for the recurrence
                if (r_t > r_kn) r_tc <= (r_kn < knot_q) ? knot_q : r_kn;
                else            r_tc <= (r_t  < knot_q) ? knot_q : r_t;
            end
            bsbe_pkg::ST_BS_CMP: begin
                if (r_t < knot_q) begin
                    r_hi <= mid;
                    r_span <= r_lo;
                end else begin
                    r_lo <= mid;
                    r_span <= mid;
                end
            end
            bsbe_pkg::ST_J_START: begin
                r_r     <= '0;
                r_saved <= '0;
            end
            bsbe_pkg::ST_RD_R:
                r_left[r_j] <= 19'(signed'({2'b0, r_tc})) - 19'(signed'({2'b0, knot_q}));
            bsbe_pkg::ST_CALC_LR:
                r_right[r_j] <= 19'(signed'({2'b0, knot_q})) - 19'(signed'({2'b0, r_tc}));
            bsbe_pkg::ST_TERM: begin
                r_den   <= 20'(r_right[r_r + 1'b1]) + 20'(r_left[r_j - r_r]);
                r_bterm <= 1'b0;
            end
            bsbe_pkg::ST_MUL, bsbe_pkg::ST_DIV_A, bsbe_pkg::ST_DIV_B: begin
                if (r_state == bsbe_pkg::ST_MUL ||
                    (r_state == bsbe_pkg::ST_DIV_A && r_cnt == 6'd0)) begin
                    // load divider: |basis*num| / |den|, sign applied after
                    r_dvd  <= DIVW'(num_abs) * DIVW'(r_basis[r_r]);
                    r_dvs  <= (r_den < 0) ? 20'(-r_den) : 20'(r_den);
                    r_neg  <= (num_sel < 0) ^ (r_den < 0);
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_cnt  <= 6'(DIVW);
                    r_bterm <= 1'b1;
                    if (r_state == bsbe_pkg::ST_DIV_A) begin
                        r_qa <= div_zero ? '0 : (r_neg ? -signed'(r_quo) : signed'(r_quo));
                    end
                end else if (r_cnt != 6'd0) begin
                    r_cnt <= r_cnt - 1'b1;
                    r_dvd <= {r_dvd[DIVW-2:0], 1'b0};
                    if (!div_try[DIVW]) begin
                        r_rem <= div_try[DIVW-1:0];
                        r_quo <= {r_quo[DIVW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DIVW-2:0], r_dvd[DIVW-1]};
                        r_quo <= {r_quo[DIVW-2:0], 1'b0};
                    end
                end
            end
            bsbe_pkg::ST_ACC: begin
                r_basis[r_r] <= sat_u((DIVW+1)'(r_saved) + (DIVW+1)'(r_qa));
                r_saved <= div_zero ? '0 : (r_neg ? -signed'(r_quo) : signed'(r_quo));
                r_r <= r_r + 1'b1;
            end
            bsbe_pkg::ST_J_END: begin
                r_basis[r_j] <= sat_u((DIVW+1)'(r_saved));
                r_j <= r_j + 1'b1;
            end
            bsbe_pkg::ST_EMIT:
                if (!r_ov || !i_out_stall) begin
                    r_out.span        <= r_span[6:0];
                    r_out.basis_index <= r_oj[2:0];
                    r_out.basis_value <= r_basis[r_oj];
                    r_out.last        <= (r_oj == r_d);
                    r_oj <= r_oj + 1'b1;
                end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ tb/bspline_basis_checker.sv @@
// ----------------------------------------------------------------------------
// B-spline basis checker
// Watches the item, result and register channels of the evaluator, keeps a
// shadow knot vector and register copy, computes the expected basis values
// for every evaluate transaction and compares each result in order.
// ----------------------------------------------------------------------------
module bspline_basis_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  wire  bsbe_pkg::t_in_item  i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  wire  bsbe_pkg::t_out_item i_out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    input  wire                 pready,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen
);

    localparam int KNOTS = 128;
    localparam int DEG_CAP = 7;
    localparam logic [2:0] ADDR_DEGREE     = 3'(4 * bsbe_pkg::REG_DEGREE);
    localparam logic [2:0] ADDR_NUM_POINTS = 3'(4 * bsbe_pkg::REG_NUM_POINTS);

    logic [16:0]  knot_shadow [KNOTS];
    logic [2:0]   degree_q;
    logic [6:0]   points_q;
    bsbe_pkg::t_out_item expected_basis [$];

    function automatic longint knot_rd(int idx);
        if (idx < KNOTS) begin
            return longint'(knot_shadow[idx]);
        end
        return 0;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v < 0) begin
            return 0;
        end
        if (v > 65536) begin
            return 65536;
        end
        return v;
    endfunction

    // Locate the span, run the triangular recurrence, queue degree+1 values
    function automatic void predict_basis(logic [16:0] t_raw);
        int        d;
        int        n;
        int        span_k;
        int        lo;
        int        hi;
        int        mid;
        longint    t;
        longint    tc;
        longint    kn;
        longint    kd;
        longint    saved;
        longint    den;
        longint    a;
        longint    b;
        longint    nb   [DEG_CAP + 2];
        longint    lft  [DEG_CAP + 2];
        longint    rgt  [DEG_CAP + 2];
        bsbe_pkg::t_out_item res;
        d = (degree_q > DEG_CAP) ? DEG_CAP : int'(degree_q);
        n = int'(points_q);
        if (n < d + 1) begin
            n = d + 1;
        end
        t = longint'(t_raw);
        kn = knot_rd(n);
        kd = knot_rd(d);
        if (t >= kn) begin
            span_k = n - 1;
        end else if (t <= kd) begin
            span_k = d;
        end else begin
            lo = d;
            hi = n;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (t < knot_rd(mid)) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
            span_k = lo;
        end
        // clamp t into the domain for the recurrence only
        tc = t;
        if (tc > kn) tc = kn;
        if (tc < kd) tc = kd;
        nb[0] = 65536;
        for (int j = 1; j <= d; j++) begin
            saved = 0;
            lft[j] = tc - knot_rd(span_k + 1 - j);
            rgt[j] = knot_rd(span_k + j) - tc;
            for (int r = 0; r < j; r++) begin
                den = rgt[r + 1] + lft[j - r];
                a = 0;
                b = 0;
                if (den != 0) begin
                    a = (nb[r] * rgt[r + 1]) / den;
                    b = (nb[r] * lft[j - r]) / den;
                end
                nb[r] = clamp_unit(saved + a);
                saved = b;
            end
            nb[j] = clamp_unit(saved);
        end
        for (int j = 0; j <= d; j++) begin
            res.span        = 7'(span_k);
            res.basis_index = 3'(j);
            res.basis_value = 17'(nb[j]);
            res.last        = (j == d);
            expected_basis.push_back(res);
        end
    endfunction

    // Compare results first, then absorb new transactions and register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            degree_q = 3'd3;
            points_q = 7'd4;
            o_fail_count = 0;
            o_results_seen = 0;
            expected_basis.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (expected_basis.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result span=%0d idx=%0d val=%0d last=%0b",
                             $time, i_out_data.span, i_out_data.basis_index,
                             i_out_data.basis_value, i_out_data.last);
                end else begin
                    if (i_out_data !== expected_basis[0]) begin
                        o_fail_count++;
                        $display("%0t: mismatch expected span=%0d idx=%0d val=%0d last=%0b",
                                 $time, expected_basis[0].span,
                                 expected_basis[0].basis_index,
                                 expected_basis[0].basis_value, expected_basis[0].last);
                        $display("%0t:          actual   span=%0d idx=%0d val=%0d last=%0b",
                                 $time, i_out_data.span, i_out_data.basis_index,
                                 i_out_data.basis_value, i_out_data.last);
                    end
                    void'(expected_basis.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.operation == bsbe_pkg::OP_WRITE) begin
                    knot_shadow[i_in_data.knot_index] = i_in_data.knot_value;
                end else begin
                    predict_basis(i_in_data.param_value);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_DEGREE) degree_q = pwdata[2:0];
                if (paddr == ADDR_NUM_POINTS) points_q = pwdata[6:0];
            end
        end
        o_pending = expected_basis.size();
    end

endmodule

@@ tb/tb_bspline_basis_evaluator.sv @@
// ----------------------------------------------------------------------------
// B-spline basis evaluator testbench
// Fills the knot vector, then steps through degree and control point
// settings, rewriting knots and evaluating t at edges, knots and at random,
// with random idle and stall bursts. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bspline_basis_evaluator;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TARGET_ITEMS   = 310;
    localparam int QUIET_FROM     = 270;
    localparam logic [2:0] ADDR_DEGREE     = 3'(4 * bsbe_pkg::REG_DEGREE);
    localparam logic [2:0] ADDR_NUM_POINTS = 3'(4 * bsbe_pkg::REG_NUM_POINTS);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    bsbe_pkg::t_in_item  i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    bsbe_pkg::t_out_item o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          items_sent;
    int          evals_sent;
    int          settings_used;
    int          idle_cycles;
    bit          quiet;
    bit          hold_req;
    int          cur_degree;
    int          cur_points;
    logic [16:0] knot_copy [128];

    bspline_basis_evaluator dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    bspline_basis_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Abort when no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bspline_basis_evaluator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one transaction, holding it until accepted
    task automatic send_item(bsbe_pkg::t_in_item item, bit allow_gap);
        if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (item.operation == bsbe_pkg::OP_EVAL) evals_sent++;
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
    endtask

    task automatic write_knot(int idx, logic [16:0] value);
        bsbe_pkg::t_in_item item;
        item.operation   = bsbe_pkg::OP_WRITE;
        item.knot_index  = 7'(idx);
        item.knot_value  = value;
        item.param_value = 17'($urandom);
        knot_copy[idx]   = value;
        send_item(item, 1'b1);
    endtask

    task automatic eval_at(logic [16:0] t, bit allow_gap);
        bsbe_pkg::t_in_item item;
        item.operation   = bsbe_pkg::OP_EVAL;
        item.knot_index  = 7'($urandom);
        item.knot_value  = 17'($urandom);
        item.param_value = t;
        send_item(item, allow_gap);
    endtask

    // Hold off new transactions until every result is in and the block settles
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(int deg, int pts);
        drain();
        reg_write(ADDR_DEGREE, 32'(deg));
        reg_write(ADDR_NUM_POINTS, 32'(pts));
        cur_degree = deg;
        cur_points = pts;
        settings_used++;
    endtask

    // Rewrite the active knots when there are at most 24: clamped and nondecreasing, or now and then shuffled
    task automatic rewrite_knots;
        int n;
        int cnt;
        int v;
        bit shuffled;
        n = (cur_points < cur_degree + 1) ? cur_degree + 1 : cur_points;
        cnt = n + cur_degree + 1;
        if (cnt > 128) cnt = 128;
        if (cnt > 24) return;
        shuffled = ($urandom_range(0, 5) == 0);
        v = 0;
        for (int i = 0; i < cnt; i++) begin
            if (shuffled) begin
                v = $urandom_range(0, 65536);
            end else if (i <= cur_degree) begin
                v = 0;
            end else if (i >= n) begin
                v = 65536;
            end else if ($urandom_range(0, 4) != 0) begin
                v = v + $urandom_range(1, 65536 / n);
                if (v > 65536) v = 65536;
            end
            write_knot(i, 17'(v));
        end
        // stray write outside the active range
        write_knot($urandom_range(cnt, 127), 17'($urandom_range(0, 131071)));
    endtask

    function automatic logic [16:0] pick_param;
        int sel;
        int n;
        sel = $urandom_range(0, 15);
        n = (cur_points < cur_degree + 1) ? cur_degree + 1 : cur_points;
        case (sel)
            0, 1: return 17'd0;
            2, 3: return 17'd65536;
            4:    return 17'($urandom_range(65537, 131071));
            5, 6, 7: return knot_copy[$urandom_range(0, n)];
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        int deg_list [10] = '{0, 1, 7, 2, 5, 7, 4, 1, 6, 3};
        int pts_list [10] = '{5, 2, 120, 8, 3, 10, 12, 127, 9, 6};
        int phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        items_sent  = 0;
        evals_sent  = 0;
        settings_used = 1;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        cur_degree  = 3;
        cur_points  = 4;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the whole store with a gently rising vector, top entry at full scale
        for (int i = 0; i < 128; i++) begin
            write_knot(i, (i == 127) ? 17'd131071 :
                          17'((i < 4) ? 0 : ((i * 65536) / 130 + $urandom_range(0, 3))));
        end

        // directed evaluations at reset settings: edges, knots, above one
        rewrite_knots();
        eval_at(17'd0, 1'b1);
        eval_at(17'd65536, 1'b1);
        eval_at(17'd131071, 1'b1);
        eval_at(knot_copy[3], 1'b1);
        eval_at(knot_copy[4], 1'b1);
        eval_at(17'd32768, 1'b1);
        eval_at(17'd1, 1'b1);

        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (phase < 10) begin
                apply_setting(deg_list[phase], pts_list[phase]);
            end else if ($urandom_range(0, 7) == 0) begin
                apply_setting($urandom_range(0, 7), $urandom_range(2, 120));
            end else begin
                apply_setting($urandom_range(0, 7), $urandom_range(2, 16));
            end
            rewrite_knots();
            if (phase == 3) begin
                // stall the result side long enough to back up the input
                hold_req = 1'b1;
                repeat (6) eval_at(pick_param(), 1'b0);
            end else begin
                repeat (8) eval_at(pick_param(), 1'b1);
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d transactions (%0d evaluations) over %0d register settings",
                 items_sent, evals_sent, settings_used);
        $display("checked %0d basis values, %0d left outstanding", results_seen, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("bspline_basis_evaluator regression: pass");
        end else begin
            $display("bspline_basis_evaluator regression: fail");
        end
        $finish;
    end

endmodule

@@ bspline_basis_evaluator.f @@
hw/rtl/bsbe_pkg.sv
hw/rtl/bspline_basis_evaluator.sv
tb/bspline_basis_checker.sv
tb/tb_bspline_basis_evaluator.sv
